FILE: src/ctk_pkg.sv
package ctk_pkg;

    localparam int TEXT_CAP = 64;

    localparam logic [62:0] VMAX = {63{1'b1}};

    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_NUMBER = 5'd2;
    localparam logic [4:0] K_INT    = 5'd3;
    localparam logic [4:0] K_RETURN = 5'd4;
    localparam logic [4:0] K_IF     = 5'd5;
    localparam logic [4:0] K_ELSE   = 5'd6;
    localparam logic [4:0] K_WHILE  = 5'd7;
    localparam logic [4:0] K_PLUS   = 5'd8;
    localparam logic [4:0] K_MINUS  = 5'd9;
    localparam logic [4:0] K_STAR   = 5'd10;
    localparam logic [4:0] K_SLASH  = 5'd11;
    localparam logic [4:0] K_LPAR   = 5'd12;
    localparam logic [4:0] K_RPAR   = 5'd13;
    localparam logic [4:0] K_LBRACE = 5'd14;
    localparam logic [4:0] K_RBRACE = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_ASSIGN = 5'd17;
    localparam logic [4:0] K_EQ     = 5'd18;
    localparam logic [4:0] K_NE     = 5'd19;
    localparam logic [4:0] K_LT     = 5'd20;
    localparam logic [4:0] K_LE     = 5'd21;
    localparam logic [4:0] K_GT     = 5'd22;
    localparam logic [4:0] K_GE     = 5'd23;
    localparam logic [4:0] K_ERROR  = 5'd24;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_BADHEX = 3'd1;
    localparam logic [2:0] E_BADNUM = 3'd2;
    localparam logic [2:0] E_BANG   = 3'd3;
    localparam logic [2:0] E_UNEXP  = 3'd4;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_EQ, M_BANG, M_LT, M_GT,
        M_IDENT, M_ZERO, M_DEC, M_HEXPRE, M_HEXRUN
    } mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  err;
        logic [62:0] val;
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic [15:0] len;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [1:0] n;
        tok_t       t0;
        tok_t       t1;
    } push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (is_digit(c)) d = c - 8'h30;
        else if (c >= "a" && c <= "f") d = c - 8'h57;
        else d = c - 8'h37;
        return d[3:0];
    endfunction

    // saturating acc * base + d, ignored past the text cap
    function automatic logic [62:0] add_digit(input logic [62:0] acc, input logic [15:0] tb,
                                              input logic [3:0] d, input logic hex);
        logic [66:0] prod;
        logic [66:0] sum;
        if (tb >= 16'(TEXT_CAP - 1)) return acc;
        if (hex) prod = {acc, 4'b0000};
        else prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        sum = prod + {63'd0, d};
        if (sum > {4'd0, VMAX}) return VMAX;
        return sum[62:0];
    endfunction

    function automatic logic [4:0] ident_kind(input logic [15:0] tb, input logic [47:0] kb);
        if (tb == 16'd3 && kb == 48'h696E74) return K_INT;
        if (tb == 16'd6 && kb == 48'h72657475726E) return K_RETURN;
        if (tb == 16'd2 && kb == 48'h6966) return K_IF;
        if (tb == 16'd4 && kb == 48'h656C7365) return K_ELSE;
        if (tb == 16'd5 && kb == 48'h7768696C65) return K_WHILE;
        return K_IDENT;
    endfunction

    function automatic tok_t mk(input logic [4:0] kind, input logic [2:0] err,
                                input logic [62:0] val, input logic [23:0] line,
                                input logic [15:0] col, input logic [31:0] off,
                                input logic [15:0] len);
        tok_t t;
        t.kind = kind;
        t.err  = err;
        t.val  = val;
        t.line = line;
        t.col  = col;
        t.off  = off;
        t.len  = len;
        t.last = 1'b0;
        return t;
    endfunction

endpackage

FILE: src/ctk_lexer.sv
module ctk_lexer
    import ctk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       action,
    input  logic [7:0] ch,
    output push_t      push
);

    mode_t       mode_reg, mode_next;
    logic [23:0] cur_line_reg, cur_line_next;
    logic [15:0] cur_col_reg, cur_col_next;
    logic [31:0] pos_reg, pos_next;
    logic [23:0] tl_reg, tl_next;
    logic [15:0] tc_reg, tc_next;
    logic [31:0] ts_reg, ts_next;
    logic [15:0] tb_reg, tb_next;
    logic [62:0] acc_reg, acc_next;
    logic [47:0] kb_reg, kb_next;

    tok_t        toks [2];
    logic [1:0]  cnt;
    logic        again;
    logic [4:0]  one;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            cur_line_reg <= 24'd1;
            cur_col_reg  <= 16'd1;
            pos_reg      <= '0;
            tl_reg       <= 24'd1;
            tc_reg       <= 16'd1;
            ts_reg       <= '0;
            tb_reg       <= '0;
            acc_reg      <= '0;
            kb_reg       <= '0;
        end else if (step) begin
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            pos_reg      <= pos_next;
            tl_reg       <= tl_next;
            tc_reg       <= tc_next;
            ts_reg       <= ts_next;
            tb_reg       <= tb_next;
            acc_reg      <= acc_next;
            kb_reg       <= kb_next;
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        pos_next      = pos_reg;
        tl_next       = tl_reg;
        tc_next       = tc_reg;
        ts_next       = ts_reg;
        tb_next       = tb_reg;
        acc_next      = acc_reg;
        kb_next       = kb_reg;
        toks[0]       = '0;
        toks[1]       = '0;
        cnt           = 2'd0;
        again         = 1'b0;
        one           = K_ASSIGN;

        if (action) begin
            // flush the pending token, then eof at the current position
            cnt = 2'd1;
            case (mode_reg)
                M_SLASH:  toks[0] = mk(K_SLASH, E_NONE, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                M_EQ:     toks[0] = mk(K_ASSIGN, E_NONE, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                M_LT:     toks[0] = mk(K_LT, E_NONE, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                M_GT:     toks[0] = mk(K_GT, E_NONE, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                M_BANG:   toks[0] = mk(K_ERROR, E_BANG, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                M_IDENT:  toks[0] = mk(ident_kind(tb_reg, kb_reg), E_NONE, '0,
                                       tl_reg, tc_reg, ts_reg, tb_reg);
                M_ZERO, M_DEC, M_HEXRUN:
                          toks[0] = mk(K_NUMBER, E_NONE, acc_reg, tl_reg, tc_reg, ts_reg, tb_reg);
                M_HEXPRE: toks[0] = mk(K_ERROR, E_BADHEX, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                default:  cnt = 2'd0;
            endcase
            toks[cnt[0]] = mk(K_EOF, E_NONE, '0, cur_line_reg, cur_col_reg, pos_reg, 16'd0);
            toks[cnt[0]].last = 1'b1;
            cnt = cnt + 2'd1;
            mode_next     = M_IDLE;
            cur_line_next = 24'd1;
            cur_col_next  = 16'd1;
            pos_next      = '0;
            tl_next       = 24'd1;
            tc_next       = 16'd1;
            ts_next       = '0;
            tb_next       = '0;
            acc_next      = '0;
            kb_next       = '0;
        end else begin
            case (mode_reg)
                M_IDLE: again = 1'b1;
                M_SLASH: begin
                    if (ch == "/") mode_next = M_LINE;
                    else if (ch == "*") mode_next = M_BLOCK;
                    else begin
                        toks[0] = mk(K_SLASH, E_NONE, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                        cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                M_LINE:  if (ch == 8'h0A) mode_next = M_IDLE;
                M_BLOCK: if (ch == "*") mode_next = M_STAR;
                M_STAR: begin
                    if (ch == "/") mode_next = M_IDLE;
                    else if (ch != "*") mode_next = M_BLOCK;
                end
                M_EQ, M_LT, M_GT, M_BANG: begin
                    case (mode_reg)
                        M_EQ:    one = K_ASSIGN;
                        M_LT:    one = K_LT;
                        M_GT:    one = K_GT;
                        default: one = K_ERROR;
                    endcase
                    cnt = 2'd1;
                    if (ch == "=") begin
                        if (tb_reg != 16'hFFFF) tb_next = tb_reg + 16'd1;
                        toks[0] = mk((one == K_ERROR) ? K_NE : one + 5'd1, E_NONE, '0,
                                     tl_reg, tc_reg, ts_reg, tb_next);
                        mode_next = M_IDLE;
                    end else begin
                        toks[0] = mk(one, (one == K_ERROR) ? E_BANG : E_NONE, '0,
                                     tl_reg, tc_reg, ts_reg, tb_reg);
                        again = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_ident(ch)) begin
                        if (tb_reg != 16'hFFFF) tb_next = tb_reg + 16'd1;
                        kb_next = {kb_reg[39:0], ch};
                    end else begin
                        toks[0] = mk(ident_kind(tb_reg, kb_reg), E_NONE, '0,
                                     tl_reg, tc_reg, ts_reg, tb_reg);
                        cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                M_ZERO, M_DEC, M_HEXPRE, M_HEXRUN: begin
                    if (mode_reg == M_ZERO && (ch == "x" || ch == "X")) begin
                        if (tb_reg != 16'hFFFF) tb_next = tb_reg + 16'd1;
                        mode_next = M_HEXPRE;
                    end else if ((mode_reg == M_ZERO || mode_reg == M_DEC) && is_digit(ch))
                    begin
                        acc_next = add_digit(acc_reg, tb_reg, hex_val(ch), 1'b0);
                        if (tb_reg != 16'hFFFF) tb_next = tb_reg + 16'd1;
                        mode_next = M_DEC;
                    end else if ((mode_reg == M_HEXPRE || mode_reg == M_HEXRUN) && is_hex(ch))
                    begin
                        acc_next = add_digit(acc_reg, tb_reg, hex_val(ch), 1'b1);
                        if (tb_reg != 16'hFFFF) tb_next = tb_reg + 16'd1;
                        mode_next = M_HEXRUN;
                    end else begin
                        cnt = 2'd1;
                        again = 1'b1;
                        if (mode_reg == M_HEXPRE)
                            toks[0] = mk(K_ERROR, E_BADHEX, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                        else if (is_ident(ch))
                            toks[0] = mk(K_ERROR, E_BADNUM, '0, tl_reg, tc_reg, ts_reg, tb_reg);
                        else
                            toks[0] = mk(K_NUMBER, E_NONE, acc_reg, tl_reg, tc_reg, ts_reg,
                                         tb_reg);
                    end
                end
                default: again = 1'b1;
            endcase

            // byte starts a fresh token unless it is whitespace
            if (again) begin
                mode_next = M_IDLE;
                if (!(ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A)) begin
                    tl_next  = cur_line_reg;
                    tc_next  = cur_col_reg;
                    ts_next  = pos_reg;
                    tb_next  = 16'd1;
                    acc_next = '0;
                    kb_next  = '0;
                    if (is_alpha(ch)) begin
                        kb_next   = {40'd0, ch};
                        mode_next = M_IDENT;
                    end else if (is_digit(ch)) begin
                        acc_next  = {59'd0, hex_val(ch)};
                        mode_next = (ch == "0") ? M_ZERO : M_DEC;
                    end else begin
                        case (ch)
                            "/": mode_next = M_SLASH;
                            "=": mode_next = M_EQ;
                            "!": mode_next = M_BANG;
                            "<": mode_next = M_LT;
                            ">": mode_next = M_GT;
                            default: begin
                                case (ch)
                                    "+": toks[cnt[0]] = mk(K_PLUS, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    "-": toks[cnt[0]] = mk(K_MINUS, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    "*": toks[cnt[0]] = mk(K_STAR, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    "(": toks[cnt[0]] = mk(K_LPAR, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    ")": toks[cnt[0]] = mk(K_RPAR, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    "{": toks[cnt[0]] = mk(K_LBRACE, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    "}": toks[cnt[0]] = mk(K_RBRACE, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    ";": toks[cnt[0]] = mk(K_SEMI, E_NONE, '0,
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                    default: toks[cnt[0]] = mk(K_ERROR, E_UNEXP, {55'd0, ch},
                                                           cur_line_reg, cur_col_reg, pos_reg, 16'd1);
                                endcase
                                cnt = cnt + 2'd1;
                            end
                        endcase
                    end
                end
            end

            if (ch == 8'h0A) begin
                if (cur_line_reg != 24'hFFFFFF) cur_line_next = cur_line_reg + 24'd1;
                cur_col_next = 16'd1;
            end else if (cur_col_reg != 16'hFFFF) begin
                cur_col_next = cur_col_reg + 16'd1;
            end
            pos_next = pos_reg + 32'd1;

            if (cnt == 2'd1) toks[0].last = 1'b1;
            if (cnt == 2'd2) toks[1].last = 1'b1;
        end

        push.n  = cnt;
        push.t0 = toks[0];
        push.t1 = toks[1];
    end

endmodule

FILE: src/ctk_out_buf.sv
module ctk_out_buf
    import ctk_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_en,
    input  push_t push,
    input  logic  rd_en,
    output logic  has_room,
    output logic  not_empty,
    output tok_t  head
);

    tok_t       mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_in;

    assign n_in       = wr_en ? push.n : 2'd0;
    assign has_room   = count_reg <= 3'd2;
    assign not_empty  = count_reg != 3'd0;
    assign head       = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, n_in} - {2'b00, rd_en};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_in;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, rd_en};
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) mem_reg[wr_ptr_reg] <= push.t0;
        if (n_in == 2'd2) mem_reg[wr_ptr_reg + 2'd1] <= push.t1;
    end

endmodule

FILE: src/c_subset_tokenizer_unit.sv
// Tokenizer for a small C subset, one source byte per beat.
// Slave channel: s_tdata[7:0] carries the byte, s_tuser[0] marks end of
// source (the byte is then ignored). Master channel: one token per beat,
// kind and error code in m_tuser, value and position in m_tdata, and
// m_tlast on the final token caused by an input beat.
// Path: a token passes from the input register through the lexer into the
// output queue, and leaves from the head of the queue.
// Throughput: one input beat per cycle while the queue has room. A byte that
// yields two tokens (it closes a pending token and forms one of its own)
// leaves one extra entry in the four-entry queue, as the master port drains
// at most one token per cycle; while more than two entries are waiting, the
// input is held.
// The end-of-source beat flushes the pending token, emits eof and returns
// the line, column and offset counters to their reset values.
// Reset (aresetn low, synchronous) empties the queue and the input
// register and puts the scanner between tokens at line 1, column 1.
// When the receiver stalls, the queue fills and the held beat waits with
// s_tready low while fewer than two entries are free; no beat is lost.
module c_subset_tokenizer_unit
    import ctk_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // ch
    input  logic [0:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // number_value, line, column, offset, length, pad
    output logic [7:0]   m_tuser,   // kind, error_code
    output logic         m_tlast
);

    logic       in_vld_reg;
    logic       in_act_reg;
    logic [7:0] in_ch_reg;
    logic       step;
    logic       has_room;
    push_t      push;
    tok_t       head;

    // advance the held beat into the lexer whenever two queue slots are free
    assign step     = in_vld_reg && has_room;
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_act_reg <= s_tuser[0];
            in_ch_reg  <= s_tdata;
        end
    end

    ctk_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .action  (in_act_reg),
        .ch      (in_ch_reg),
        .push    (push)
    );

    ctk_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (step),
        .push      (push),
        .rd_en     (m_tvalid && m_tready),
        .has_room  (has_room),
        .not_empty (m_tvalid),
        .head      (head)
    );

    assign m_tdata = {1'b0, head.len, head.off, head.col, head.line, head.val};
    assign m_tuser = {head.err, head.kind};
    assign m_tlast = head.last;

endmodule

FILE: src/ctk_checker.sv
module ctk_checker
    import ctk_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic [7:0]   m_tuser,
    input logic         m_tlast
);

    // nothing leaves straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token beat right after reset");

    // a stalled token holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled token changed");

    // eof is always the final token of its beat, with no length and value
    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4:0] == K_EOF |-> m_tlast && m_tdata[150:135] == 16'd0
        && m_tdata[62:0] == 63'd0)
        else $error("malformed eof token");

    // an error code comes with the error kind and only then
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[4:0] == K_ERROR) == (m_tuser[7:5] != E_NONE))
        else $error("error code and kind disagree");

endmodule

bind c_subset_tokenizer_unit ctk_checker u_ctk_checker (.*);
